FILE: design/pecs_pkg.sv
// Shared types and constants for the endpoint and conversation statistics block.
package pecs_pkg;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned TOTAL_WIDTH  = 32;
  localparam int unsigned NTAB         = 6;
  localparam int unsigned SLOT_W       = $clog2(ENTRIES);
  localparam int unsigned CNT_W        = $clog2(ENTRIES) + 1;
  localparam int unsigned IDX_CMP_W    = 11;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

  // Result status codes
  localparam logic [1:0] ST_COUNTED = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  // Request types
  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] captured_length;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
    logic [2:0]  table_select;
    logic [5:0]  entry_index;
  } pecs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        entry_valid;
    logic [47:0] key_first;
    logic [47:0] key_second;
    logic [31:0] byte_total;
    logic [31:0] packet_total;
  } pecs_out_t;

  // Query token that walks down a row of cells, one cell per cycle
  typedef struct packed {
    logic                   act;
    logic                   is_read;
    logic                   hit;
    logic [47:0]            ka;
    logic [47:0]            kb;
    logic [15:0]            len;
    logic [5:0]             idx;
    logic [TOTAL_WIDTH-1:0] bytes;
    logic [TOTAL_WIDTH-1:0] pkts;
  } pecs_tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_OUT
  } pecs_state_e;

endpackage

FILE: design/packet_endpoint_conversation_stats.sv
// Top level: request control and six table rows of slot cells.
// The result is registered as the token leaves the last cell; a bad header skips the rows.
// One request at a time, the input stalling until the result is taken;
// the query token walks the chain of ENTRIES slot cells, one cell per cycle.
// Reset clears slot valid bits and control; no clearing pass is needed.
module packet_endpoint_conversation_stats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pecs_pkg::pecs_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pecs_pkg::pecs_out_t out_o
);
  import pecs_pkg::*;

  pecs_state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic            rd_q;
  logic [2:0]      sel_q;
  pecs_out_t       res_q, res_d;
  logic            res_ld;
  logic            accept, bad_hdr, tail_done;
  pecs_tok_t       heads [NTAB];
  pecs_tok_t       tails [NTAB];
  pecs_tok_t       rd_tok;
  logic            any_miss;

  assign accept    = in_valid_i && !in_stall_o;
  assign bad_hdr   = (in_i.ip_header_words < MIN_HDR_WORDS) ||
                     (in_i.tcp_header_words < MIN_HDR_WORDS);
  assign tail_done = (state_q == S_RUN) && (cnt_q == '0);

  // Token injection into each row
  always_comb begin
    for (int t = 0; t < NTAB; t++) begin
      heads[t].is_read = in_i.req_type;
      heads[t].hit     = 1'b0;
      heads[t].len     = in_i.captured_length;
      heads[t].idx     = in_i.entry_index;
      heads[t].bytes   = '0;
      heads[t].pkts    = '0;
      heads[t].ka      = '0;
      heads[t].kb      = '0;
      if (in_i.req_type == REQ_READ) begin
        heads[t].act = accept && (32'(in_i.table_select) == t);
      end else begin
        heads[t].act = accept && !bad_hdr;
      end
    end
    if (in_i.req_type == REQ_COUNT) begin
      heads[0].ka = 48'(in_i.src_ip);
      heads[1].ka = in_i.src_mac;
      heads[2].ka = 48'(in_i.dst_ip);
      heads[3].ka = in_i.dst_mac;
      heads[4].ka = 48'(in_i.src_ip);
      heads[4].kb = 48'(in_i.dst_ip);
      heads[5].ka = in_i.src_mac;
      heads[5].kb = in_i.dst_mac;
    end
  end

  for (genvar t = 0; t < NTAB; t++) begin : g_row
    pecs_row u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .head_i (heads[t]),
      .tail_o (tails[t])
    );
  end

  // Result assembly
  always_comb begin
    any_miss = 1'b0;
    for (int t = 0; t < NTAB; t++) begin
      any_miss = any_miss | !tails[t].hit;
    end
    rd_tok = '0;
    case (sel_q)
      3'd0: rd_tok = tails[0];
      3'd1: rd_tok = tails[1];
      3'd2: rd_tok = tails[2];
      3'd3: rd_tok = tails[3];
      3'd4: rd_tok = tails[4];
      3'd5: rd_tok = tails[5];
      default: rd_tok = '0;
    endcase
    res_d  = '0;
    res_ld = 1'b0;
    if (state_q == S_IDLE && accept && in_i.req_type == REQ_COUNT && bad_hdr) begin
      res_ld       = 1'b1;
      res_d.status = ST_BAD_HDR;
    end else if (tail_done) begin
      res_ld = 1'b1;
      if (rd_q) begin
        res_d.status = ST_READ;
        if (rd_tok.hit) begin
          res_d.entry_valid  = 1'b1;
          res_d.key_first    = rd_tok.ka;
          res_d.key_second   = rd_tok.kb;
          res_d.byte_total   = 32'(rd_tok.bytes);
          res_d.packet_total = 32'(rd_tok.pkts);
        end
      end else begin
        res_d.status = any_miss ? ST_FULL : ST_COUNTED;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.req_type == REQ_COUNT && bad_hdr) begin
            state_d = S_OUT;
          end else begin
            state_d = S_RUN;
            cnt_d   = CNT_W'(ENTRIES - 1);
          end
        end
      end
      S_RUN: begin
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
  end

  assign out_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rd_q    <= 1'b0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (accept) begin
        rd_q  <= in_i.req_type;
        sel_q <= in_i.table_select;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld) res_q <= res_d;
  end

endmodule

FILE: design/pecs_cell.sv
// One table slot: holds a key and its totals, updates or reads as the token passes.
module pecs_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [pecs_pkg::SLOT_W-1:0] slot_i,
  input  pecs_pkg::pecs_tok_t     tok_i,
  output pecs_pkg::pecs_tok_t     tok_o
);
  import pecs_pkg::*;

  logic                   vld_q, vld_d;
  logic                   act_q;
  logic [47:0]            ka_q, ka_d, kb_q, kb_d;
  logic [TOTAL_WIDTH-1:0] by_q, by_d, pk_q, pk_d;
  pecs_tok_t              tok_q, tok_d;
  logic [TOTAL_WIDTH:0]   by_sum, pk_sum, len_sum;
  logic                   key_eq, slot_eq;

  assign by_sum  = {1'b0, by_q} + (TOTAL_WIDTH+1)'(tok_i.len);
  assign pk_sum  = {1'b0, pk_q} + (TOTAL_WIDTH+1)'(1);
  assign len_sum = (TOTAL_WIDTH+1)'(tok_i.len);
  assign key_eq  = (ka_q == tok_i.ka) && (kb_q == tok_i.kb);
  assign slot_eq = IDX_CMP_W'(tok_i.idx) == IDX_CMP_W'(slot_i);

  // Slot update and token hand-off
  always_comb begin
    tok_d = tok_i;
    vld_d = vld_q;
    ka_d  = ka_q;
    kb_d  = kb_q;
    by_d  = by_q;
    pk_d  = pk_q;
    if (tok_i.act && !tok_i.is_read && !tok_i.hit) begin
      if (vld_q && key_eq) begin
        by_d = by_sum[TOTAL_WIDTH] ? '1 : by_sum[TOTAL_WIDTH-1:0];
        pk_d = pk_sum[TOTAL_WIDTH] ? '1 : pk_sum[TOTAL_WIDTH-1:0];
        tok_d.hit = 1'b1;
      end else if (!vld_q) begin
        // first free slot takes the new key
        vld_d = 1'b1;
        ka_d  = tok_i.ka;
        kb_d  = tok_i.kb;
        by_d  = len_sum[TOTAL_WIDTH] ? '1 : len_sum[TOTAL_WIDTH-1:0];
        pk_d  = TOTAL_WIDTH'(1);
        tok_d.hit = 1'b1;
      end
    end else if (tok_i.act && tok_i.is_read && slot_eq && vld_q) begin
      tok_d.hit   = 1'b1;
      tok_d.ka    = ka_q;
      tok_d.kb    = kb_q;
      tok_d.bytes = by_q;
      tok_d.pkts  = pk_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      act_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      act_q <= tok_d.act;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    ka_q  <= ka_d;
    kb_q  <= kb_d;
    by_q  <= by_d;
    pk_q  <= pk_d;
    tok_q <= tok_d;
  end

  // Outgoing token takes its active flag from the reset register
  always_comb begin
    tok_o     = tok_q;
    tok_o.act = act_q;
  end

endmodule

FILE: design/pecs_row.sv
// One keyed table: a chain of slot cells the query token walks through.
module pecs_row (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pecs_pkg::pecs_tok_t head_i,
  output pecs_pkg::pecs_tok_t tail_o
);
  import pecs_pkg::*;

  pecs_tok_t link [ENTRIES+1];

  assign link[0] = head_i;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pecs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .slot_i (SLOT_W'(g)),
      .tok_i  (link[g]),
      .tok_o  (link[g+1])
    );
  end

  assign tail_o = link[ENTRIES];

endmodule
